// ===== rtl/csc_pkg.sv =====
// Shared types and constants for the calculator token scanner.
`default_nettype none

package csc_pkg;

  localparam int unsigned POSITION_BITS = 16;
  localparam int unsigned OUT_POS_BITS  = 16;

  localparam logic [3:0] KIND_PLUS   = 4'd0;
  localparam logic [3:0] KIND_MINUS  = 4'd1;
  localparam logic [3:0] KIND_MUL    = 4'd2;
  localparam logic [3:0] KIND_DIV    = 4'd3;
  localparam logic [3:0] KIND_ASSIGN = 4'd4;
  localparam logic [3:0] KIND_LPAREN = 4'd5;
  localparam logic [3:0] KIND_RPAREN = 4'd6;
  localparam logic [3:0] KIND_FACT   = 4'd7;
  localparam logic [3:0] KIND_SEMI   = 4'd8;
  localparam logic [3:0] KIND_INT    = 4'd9;
  localparam logic [3:0] KIND_IDENT  = 4'd10;
  localparam logic [3:0] KIND_VAR    = 4'd11;
  localparam logic [3:0] KIND_END    = 4'd12;
  localparam logic [3:0] KIND_ERROR  = 4'd13;

  localparam logic [1:0] RUN_NONE  = 2'd0;
  localparam logic [1:0] RUN_INT   = 2'd1;
  localparam logic [1:0] RUN_IDENT = 2'd2;

  localparam logic [2:0] IDENT_LEN_MAX = 3'd7;
  localparam logic [2:0] KEYWORD_LEN   = 3'd3;

  typedef struct packed {
    logic [7:0] char_code;
    logic       end_of_input;
  } chr_t;

  typedef struct packed {
    logic [3:0]              token_kind;
    logic [OUT_POS_BITS-1:0] token_line;
    logic [OUT_POS_BITS-1:0] token_column;
    logic                    last_of_run;
  } tok_t;

  typedef struct packed {
    logic [1:0] num;
    tok_t       first;
    tok_t       second;
  } scan_res_t;

endpackage

`default_nettype wire

// ===== rtl/csc_if.sv =====
// Valid/ready channel interfaces for source bytes and tokens.
`default_nettype none

interface csc_chr_if;
  logic          valid;
  logic          ready;
  csc_pkg::chr_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface csc_tok_if;
  logic          valid;
  logic          ready;
  csc_pkg::tok_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/calculator_token_scanner.sv =====
// Top level of the calculator token scanner.
//
//  channel  dir  modport  payload
//  chr_i    in   sink     char_code[7:0], end_of_input
//  tok_o    out  source   token_kind[3:0], token_line[15:0], token_column[15:0], last_of_run
//
// One byte per cycle while the token queue has room: a request is held in the
// input register, is decoded into at most two tokens and lands in a three-entry
// token queue. A byte that yields two tokens pushes both at once; the input stalls
// while the queue holds more than one token.
// Reset clears scanner state, positions and both valid flags.
`default_nettype none

module calculator_token_scanner #(
  parameter int unsigned PositionBits = csc_pkg::POSITION_BITS
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  csc_chr_if.sink  chr_i,
  csc_tok_if.source tok_o
);

  logic               vld_q, vld_d;
  csc_pkg::chr_t      chr_q;
  logic               room, step;
  csc_pkg::scan_res_t res;

  assign step        = vld_q && room;
  assign chr_i.ready = !vld_q || step;

  always_comb begin
    vld_d = vld_q;
    if (chr_i.valid && chr_i.ready) begin
      vld_d = 1'b1;
    end else if (step) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (chr_i.valid && chr_i.ready) begin
      chr_q <= chr_i.data;
    end
  end

  csc_scan #(
    .PositionBits(PositionBits)
  ) u_scan (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .item_i(chr_q),
    .res_o (res)
  );

  csc_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (step ? res : '0),
    .room_o (room),
    .valid_o(tok_o.valid),
    .ready_i(tok_o.ready),
    .data_o (tok_o.data)
  );

endmodule

`default_nettype wire

// ===== rtl/csc_scan.sv =====
// Scanner state and per-byte token decode.
`default_nettype none

module csc_scan #(
  parameter int unsigned PositionBits = csc_pkg::POSITION_BITS
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              step_i,
  input  wire csc_pkg::chr_t     item_i,
  output      csc_pkg::scan_res_t res_o
);

  localparam logic [PositionBits-1:0] PosMax = {PositionBits{1'b1}};

  logic [1:0]              run_q, run_d;
  logic [2:0]              len_q, len_d;
  logic                    kw_q, kw_d;
  logic [PositionBits-1:0] start_line_q, start_line_d;
  logic [PositionBits-1:0] start_col_q, start_col_d;
  logic [PositionBits-1:0] line_q, line_d;
  logic [PositionBits-1:0] col_q, col_d;

  function automatic logic [csc_pkg::OUT_POS_BITS-1:0] clip(input logic [PositionBits-1:0] v);
    logic [31:0] ext;
    ext = 32'(v);
    return (ext > 32'h0000_FFFF) ? '1 : ext[csc_pkg::OUT_POS_BITS-1:0];
  endfunction

  function automatic logic kw_char_ok(input logic [7:0] c, input logic [1:0] idx);
    logic [7:0] lc;
    lc = (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    case (idx)
      2'd0:    return lc == "v";
      2'd1:    return lc == "a";
      2'd2:    return lc == "r";
      default: return 1'b0;
    endcase
  endfunction

  logic [7:0] c;
  logic       eoi, dig, alpha, space, is_op;
  logic [3:0] op_kind;
  logic       pending, cont, emit_run, has_second;
  logic [3:0] run_kind_tok, second_kind;
  logic [2:0] note_len;
  logic       note_kw;
  csc_pkg::tok_t run_tok, sec_tok;

  always_comb begin
    c     = item_i.char_code;
    eoi   = item_i.end_of_input;
    dig   = c >= "0" && c <= "9";
    alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    space = c == " " || (c >= 8'd9 && c <= 8'd13);
    is_op = 1'b1;
    case (c)
      "+":     op_kind = csc_pkg::KIND_PLUS;
      "-":     op_kind = csc_pkg::KIND_MINUS;
      "*":     op_kind = csc_pkg::KIND_MUL;
      "/":     op_kind = csc_pkg::KIND_DIV;
      "=":     op_kind = csc_pkg::KIND_ASSIGN;
      "(":     op_kind = csc_pkg::KIND_LPAREN;
      ")":     op_kind = csc_pkg::KIND_RPAREN;
      "!":     op_kind = csc_pkg::KIND_FACT;
      ";":     op_kind = csc_pkg::KIND_SEMI;
      default: begin
        op_kind = csc_pkg::KIND_ERROR;
        is_op   = 1'b0;
      end
    endcase

    pending  = run_q != csc_pkg::RUN_NONE;
    cont     = pending && !eoi &&
               ((run_q == csc_pkg::RUN_INT && dig) ||
                (run_q == csc_pkg::RUN_IDENT && (alpha || dig)));
    emit_run = pending && !cont;

    if (run_q == csc_pkg::RUN_INT) begin
      run_kind_tok = csc_pkg::KIND_INT;
    end else if (kw_q && len_q == csc_pkg::KEYWORD_LEN) begin
      run_kind_tok = csc_pkg::KIND_VAR;
    end else begin
      run_kind_tok = csc_pkg::KIND_IDENT;
    end

    has_second  = 1'b0;
    second_kind = csc_pkg::KIND_ERROR;
    if (!cont) begin
      if (eoi) begin
        has_second  = 1'b1;
        second_kind = csc_pkg::KIND_END;
      end else if (space || dig || alpha) begin
        has_second = 1'b0;
      end else begin
        has_second  = 1'b1;
        second_kind = is_op ? op_kind : csc_pkg::KIND_ERROR;
      end
    end

    run_tok.token_kind   = run_kind_tok;
    run_tok.token_line   = clip(start_line_q);
    run_tok.token_column = clip(start_col_q);
    run_tok.last_of_run  = !has_second;
    sec_tok.token_kind   = second_kind;
    sec_tok.token_line   = clip(line_q);
    sec_tok.token_column = clip(col_q);
    sec_tok.last_of_run  = 1'b1;

    res_o.num    = 2'(emit_run) + 2'(has_second);
    res_o.first  = emit_run ? run_tok : sec_tok;
    res_o.second = sec_tok;

    // identifier byte bookkeeping: continue current run or start a fresh one
    if (cont) begin
      note_kw  = kw_q && (len_q < csc_pkg::KEYWORD_LEN) && kw_char_ok(c, len_q[1:0]);
      note_len = (len_q < csc_pkg::IDENT_LEN_MAX) ? len_q + 3'd1 : len_q;
    end else begin
      note_kw  = kw_char_ok(c, 2'd0);
      note_len = 3'd1;
    end

    run_d        = run_q;
    len_d        = len_q;
    kw_d         = kw_q;
    start_line_d = start_line_q;
    start_col_d  = start_col_q;
    line_d       = line_q;
    col_d        = col_q;

    if (step_i) begin
      if (cont) begin
        if (run_q == csc_pkg::RUN_IDENT) begin
          len_d = note_len;
          kw_d  = note_kw;
        end
      end else if (!eoi && (dig || alpha)) begin
        run_d        = dig ? csc_pkg::RUN_INT : csc_pkg::RUN_IDENT;
        start_line_d = line_q;
        start_col_d  = col_q;
        len_d        = dig ? 3'd0 : note_len;
        kw_d         = dig ? 1'b1 : note_kw;
      end else begin
        run_d = csc_pkg::RUN_NONE;
        len_d = 3'd0;
        kw_d  = 1'b1;
      end

      if (!eoi) begin
        if (c == 8'h0A) begin
          if (line_q != PosMax) begin
            line_d = line_q + 1'b1;
          end
          col_d = '0;
        end else if (col_q != PosMax) begin
          col_d = col_q + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q        <= csc_pkg::RUN_NONE;
      len_q        <= 3'd0;
      kw_q         <= 1'b1;
      start_line_q <= '0;
      start_col_q  <= '0;
      line_q       <= '0;
      col_q        <= '0;
    end else begin
      run_q        <= run_d;
      len_q        <= len_d;
      kw_q         <= kw_d;
      start_line_q <= start_line_d;
      start_col_q  <= start_col_d;
      line_q       <= line_d;
      col_q        <= col_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/csc_outbuf.sv =====
// Three-entry token queue that takes up to two tokens per cycle.
`default_nettype none

module csc_outbuf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire csc_pkg::scan_res_t push_i,
  output      logic               room_o,
  output      logic               valid_o,
  input  wire logic               ready_i,
  output      csc_pkg::tok_t      data_o
);

  csc_pkg::tok_t slots_q [3];
  csc_pkg::tok_t slots_d [3];
  logic [1:0]    cnt_q, cnt_d;
  logic [1:0]    base;
  logic          pop;

  assign valid_o = cnt_q != 2'd0;
  assign data_o  = slots_q[0];
  assign room_o  = cnt_q <= 2'd1;
  assign pop     = valid_o && ready_i;

  always_comb begin
    base = cnt_q - 2'(pop);
    // advance queue on pop
    slots_d[0] = pop ? slots_q[1] : slots_q[0];
    slots_d[1] = pop ? slots_q[2] : slots_q[1];
    slots_d[2] = slots_q[2];
    if (push_i.num != 2'd0) begin
      slots_d[base] = push_i.first;
    end
    if (push_i.num == 2'd2) begin
      slots_d[2'(base + 2'd1)] = push_i.second;
    end
    cnt_d = base + push_i.num;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slots_q <= slots_d;
  end

endmodule

`default_nettype wire

// ===== rtl/csc_checker.sv =====
// Port-level checks for the calculator token scanner, bound to the top level.
`default_nettype none

module csc_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          tok_valid_i,
  input wire logic          tok_ready_i,
  input wire csc_pkg::tok_t tok_data_i
);

  // queue empties under reset
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |-> !tok_valid_i)
    else $error("token valid during reset");

  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tok_valid_i |-> tok_data_i.token_kind <= csc_pkg::KIND_ERROR)
    else $error("token kind out of range");

  // only a finished run can be followed by another token of the same byte
  a_last_run_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid_i && !tok_data_i.last_of_run) |->
      (tok_data_i.token_kind == csc_pkg::KIND_INT ||
       tok_data_i.token_kind == csc_pkg::KIND_IDENT ||
       tok_data_i.token_kind == csc_pkg::KIND_VAR))
    else $error("non-final token is not a run token");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tok_valid_i && !tok_ready_i) |=> (tok_valid_i && $stable(tok_data_i)))
    else $error("stalled token changed");

endmodule

bind calculator_token_scanner csc_checker u_csc_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .tok_valid_i(tok_o.valid),
  .tok_ready_i(tok_o.ready),
  .tok_data_i (tok_o.data)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the calculator token scanner: directed table, random source text.
module testbench;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 340;
  localparam int unsigned HOLD_OFF       = 400;
  localparam int unsigned POS_BITS       = csc_pkg::POSITION_BITS;
  localparam int unsigned OUT_BITS       = csc_pkg::OUT_POS_BITS;
  localparam logic [POS_BITS-1:0] POS_MAX = '1;
  localparam longint unsigned OUT_MAX = (64'd1 << OUT_BITS) - 1;
  localparam logic [23:0] KW_TEXT = "var";
  localparam logic [71:0] OP_CHARS = "+-*/=()!;";

  typedef struct packed {
    csc_pkg::chr_t req;
    logic          pin;
    csc_pkg::tok_t want;
  } dir_row_t;

  typedef struct {
    logic          pin;
    csc_pkg::tok_t want;
  } pin_tag_t;

  localparam int DIR_ROWS = 25;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{'{"+", 1'b0}, 1'b1, '{csc_pkg::KIND_PLUS, 16'd0, 16'd0, 1'b1}},
    '{'{"-", 1'b0}, 1'b1, '{csc_pkg::KIND_MINUS, 16'd0, 16'd1, 1'b1}},
    '{'{"*", 1'b0}, 1'b1, '{csc_pkg::KIND_MUL, 16'd0, 16'd2, 1'b1}},
    '{'{"/", 1'b0}, 1'b1, '{csc_pkg::KIND_DIV, 16'd0, 16'd3, 1'b1}},
    '{'{"=", 1'b0}, 1'b1, '{csc_pkg::KIND_ASSIGN, 16'd0, 16'd4, 1'b1}},
    '{'{"(", 1'b0}, 1'b1, '{csc_pkg::KIND_LPAREN, 16'd0, 16'd5, 1'b1}},
    '{'{")", 1'b0}, 1'b1, '{csc_pkg::KIND_RPAREN, 16'd0, 16'd6, 1'b1}},
    '{'{"!", 1'b0}, 1'b1, '{csc_pkg::KIND_FACT, 16'd0, 16'd7, 1'b1}},
    '{'{";", 1'b0}, 1'b1, '{csc_pkg::KIND_SEMI, 16'd0, 16'd8, 1'b1}},
    '{'{8'h00, 1'b0}, 1'b1, '{csc_pkg::KIND_ERROR, 16'd0, 16'd9, 1'b1}},
    '{'{8'hFF, 1'b0}, 1'b1, '{csc_pkg::KIND_ERROR, 16'd0, 16'd10, 1'b1}},
    '{'{8'h80, 1'b0}, 1'b1, '{csc_pkg::KIND_ERROR, 16'd0, 16'd11, 1'b1}},
    '{'{"\n", 1'b0}, 1'b0, '0},
    '{'{"V", 1'b0}, 1'b0, '0},
    '{'{"a", 1'b0}, 1'b0, '0},
    '{'{"R", 1'b0}, 1'b0, '0},
    '{'{")", 1'b0}, 1'b0, '0},
    '{'{"0", 1'b0}, 1'b0, '0},
    '{'{"7", 1'b0}, 1'b0, '0},
    '{'{"x", 1'b0}, 1'b0, '0},
    '{'{8'h00, 1'b1}, 1'b0, '0},
    '{'{8'hFF, 1'b1}, 1'b1, '{csc_pkg::KIND_END, 16'd1, 16'd7, 1'b1}},
    '{'{"\t", 1'b0}, 1'b0, '0},
    '{'{"v", 1'b0}, 1'b0, '0},
    '{'{"?", 1'b0}, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b1;

  csc_chr_if chr_bus ();
  csc_tok_if tok_bus ();

  calculator_token_scanner u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .chr_i(chr_bus),
    .tok_o(tok_bus)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // scanner state mirrored by the predictor
  logic [1:0]          pend_run = csc_pkg::RUN_NONE;
  logic [2:0]          word_len = '0;
  logic                kw_match = 1'b1;
  logic [POS_BITS-1:0] pend_line = '0;
  logic [POS_BITS-1:0] pend_col = '0;
  logic [POS_BITS-1:0] at_line = '0;
  logic [POS_BITS-1:0] at_col = '0;

  csc_pkg::tok_t pending_tokens [$];
  pin_tag_t      req_pins [$];

  int unsigned snd_idle_pct = 30;
  int unsigned rcv_idle_pct = 53;
  int unsigned hold_left = 0;
  int unsigned offered = 0;
  int unsigned quiet_cycles = 0;
  int unsigned errors = 0;
  int unsigned tokens_checked = 0;
  int unsigned bytes_in = 0;
  int unsigned marks_in = 0;
  int unsigned kind_seen [16];

  function automatic logic is_digit(logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic logic is_letter(logic [7:0] b);
    return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
  endfunction

  function automatic csc_pkg::tok_t make_token(logic [3:0] kind, logic [POS_BITS-1:0] ln,
                                               logic [POS_BITS-1:0] cl);
    csc_pkg::tok_t t;
    t.token_kind   = kind;
    t.token_line   = (ln > OUT_MAX) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(ln);
    t.token_column = (cl > OUT_MAX) ? OUT_BITS'(OUT_MAX) : OUT_BITS'(cl);
    t.last_of_run  = 1'b0;
    return t;
  endfunction

  function automatic void track_keyword(logic [7:0] b);
    logic [7:0] low;
    low = (b >= "A" && b <= "Z") ? b + 8'd32 : b;
    if (word_len >= csc_pkg::KEYWORD_LEN) begin
      kw_match = 1'b0;
    end else if (low != KW_TEXT[8*(2-word_len) +: 8]) begin
      kw_match = 1'b0;
    end
    if (word_len < csc_pkg::IDENT_LEN_MAX) word_len++;
  endfunction

  function automatic void move_cursor(logic [7:0] b);
    if (b == "\n") begin
      if (at_line != POS_MAX) at_line++;
      at_col = '0;
    end else if (at_col != POS_MAX) begin
      at_col++;
    end
  endfunction

  function automatic void scan_byte(csc_pkg::chr_t c);
    csc_pkg::tok_t made [2];
    int            n;
    logic [7:0]    b;
    logic [3:0]    op;
    logic          is_op;
    n = 0;
    b = c.char_code;
    if (pend_run != csc_pkg::RUN_NONE) begin
      if (!c.end_of_input && ((pend_run == csc_pkg::RUN_INT && is_digit(b)) ||
          (pend_run == csc_pkg::RUN_IDENT && (is_letter(b) || is_digit(b))))) begin
        if (pend_run == csc_pkg::RUN_IDENT) track_keyword(b);
        move_cursor(b);
        return;
      end
      made[n] = make_token((pend_run == csc_pkg::RUN_INT) ? csc_pkg::KIND_INT :
                           (kw_match && word_len == csc_pkg::KEYWORD_LEN) ?
                           csc_pkg::KIND_VAR : csc_pkg::KIND_IDENT,
                           pend_line, pend_col);
      n++;
      pend_run = csc_pkg::RUN_NONE;
      word_len = '0;
      kw_match = 1'b1;
    end
    is_op = 1'b1;
    op = csc_pkg::KIND_PLUS;
    case (b)
      "+": op = csc_pkg::KIND_PLUS;
      "-": op = csc_pkg::KIND_MINUS;
      "*": op = csc_pkg::KIND_MUL;
      "/": op = csc_pkg::KIND_DIV;
      "=": op = csc_pkg::KIND_ASSIGN;
      "(": op = csc_pkg::KIND_LPAREN;
      ")": op = csc_pkg::KIND_RPAREN;
      "!": op = csc_pkg::KIND_FACT;
      ";": op = csc_pkg::KIND_SEMI;
      default: is_op = 1'b0;
    endcase
    if (c.end_of_input) begin
      made[n] = make_token(csc_pkg::KIND_END, at_line, at_col);
      n++;
    end else if (b == " " || (b >= 8'd9 && b <= 8'd13)) begin
      // whitespace emits nothing
    end else if (is_op) begin
      made[n] = make_token(op, at_line, at_col);
      n++;
    end else if (is_digit(b) || is_letter(b)) begin
      pend_run  = is_digit(b) ? csc_pkg::RUN_INT : csc_pkg::RUN_IDENT;
      pend_line = at_line;
      pend_col  = at_col;
      word_len  = '0;
      kw_match  = 1'b1;
      if (pend_run == csc_pkg::RUN_IDENT) track_keyword(b);
    end else begin
      made[n] = make_token(csc_pkg::KIND_ERROR, at_line, at_col);
      n++;
    end
    if (!c.end_of_input) move_cursor(b);
    for (int i = 0; i < n; i++) begin
      if (i == n - 1) made[i].last_of_run = 1'b1;
      pending_tokens.push_back(made[i]);
    end
  endfunction

  task automatic push_char(csc_pkg::chr_t c, logic pin, csc_pkg::tok_t want);
    pin_tag_t tag;
    tag.pin  = pin;
    tag.want = want;
    req_pins.push_back(tag);
    while ($urandom_range(99) < snd_idle_pct) begin
      chr_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    chr_bus.data  <= c;
    chr_bus.valid <= 1'b1;
    offered++;
    do @(posedge clk_i); while (!chr_bus.ready);
  endtask

  task automatic send_segment();
    int unsigned pick;
    int unsigned len;
    int unsigned w;
    int unsigned i;
    logic [7:0]  b;
    logic        like_kw;
    pick = $urandom_range(99);
    if (pick < 28) begin
      like_kw = ($urandom_range(2) == 0);
      len = like_kw ? $urandom_range(2, 4) : $urandom_range(1, 10);
      for (i = 0; i < len; i++) begin
        w = $urandom_range(2);
        if (like_kw && i < 3) begin
          b = KW_TEXT[8*(2-i) +: 8];
        end else if (i == 0 || w != 0) begin
          b = 8'($urandom_range(25)) + "a";
        end else begin
          b = 8'($urandom_range(9)) + "0";
        end
        if (is_letter(b) && $urandom_range(1) == 1) b = b - 8'd32;
        push_char(csc_pkg::chr_t'{b, 1'b0}, 1'b0, '0);
      end
    end else if (pick < 45) begin
      len = $urandom_range(1, 6);
      for (i = 0; i < len; i++) begin
        push_char(csc_pkg::chr_t'{8'($urandom_range(9)) + "0", 1'b0}, 1'b0, '0);
      end
    end else if (pick < 67) begin
      push_char(csc_pkg::chr_t'{OP_CHARS[8*$urandom_range(8) +: 8], 1'b0}, 1'b0, '0);
    end else if (pick < 87) begin
      w = $urandom_range(8, 13);
      b = (w == 8) ? " " : 8'(w);
      push_char(csc_pkg::chr_t'{b, 1'b0}, 1'b0, '0);
    end else if (pick < 95) begin
      push_char(csc_pkg::chr_t'{8'($urandom_range(255)), 1'b0}, 1'b0, '0);
    end else begin
      push_char(csc_pkg::chr_t'{8'($urandom_range(255)), 1'b1}, 1'b0, '0);
    end
  endtask

  initial begin
    tok_bus.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_left > 0) begin
        tok_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        tok_bus.ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    csc_pkg::tok_t got;
    csc_pkg::tok_t want;
    pin_tag_t      tag;
    int unsigned   queued;
    if (rst_ni) begin
      if (tok_bus.valid && tok_bus.ready) begin
        got = tok_bus.data;
        if (pending_tokens.size() == 0) begin
          errors++;
          if (errors <= 10) begin
            $display("unexpected token: kind %0d at %0d:%0d last %0b",
                     got.token_kind, got.token_line, got.token_column, got.last_of_run);
          end
        end else begin
          want = pending_tokens.pop_front();
          if (got.token_kind !== want.token_kind || got.token_line !== want.token_line ||
              got.token_column !== want.token_column ||
              got.last_of_run !== want.last_of_run) begin
            errors++;
            if (errors <= 10) begin
              $display("token %0d: expected kind %0d at %0d:%0d last %0b,",
                       tokens_checked, want.token_kind, want.token_line, want.token_column,
                       want.last_of_run);
              $display("  got kind %0d at %0d:%0d last %0b",
                       got.token_kind, got.token_line, got.token_column, got.last_of_run);
            end
          end
          kind_seen[want.token_kind]++;
        end
        tokens_checked++;
      end
      if (chr_bus.valid && chr_bus.ready) begin
        tag = req_pins.pop_front();
        queued = pending_tokens.size();
        scan_byte(chr_bus.data);
        if (tag.pin && pending_tokens.size() == queued + 1) begin
          pending_tokens[pending_tokens.size() - 1] = tag.want;
        end
        if (chr_bus.data.end_of_input) marks_in++;
        else bytes_in++;
      end
      if ((chr_bus.valid && chr_bus.ready) || (tok_bus.valid && tok_bus.ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    int unsigned start;
    int unsigned i;
    rst_ni        <= 1'b0;
    chr_bus.valid <= 1'b0;
    chr_bus.data  <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (i = 0; i < DIR_ROWS; i++) begin
      push_char(DIR_TABLE[i].req, DIR_TABLE[i].pin, DIR_TABLE[i].want);
    end

    for (int phase = 0; phase < 3; phase++) begin
      snd_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 53 : 0;
      rcv_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 30 : 0;
      // hold off the token side so the queue fills and back-pressures the input
      if (phase == 2) hold_left = HOLD_OFF;
      start = offered;
      while (offered - start < PHASE_ITEMS) send_segment();
    end

    // flush any pending run
    push_char(csc_pkg::chr_t'{8'h00, 1'b1}, 1'b0, '0);
    chr_bus.valid <= 1'b0;

    while (pending_tokens.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);

    $display("Scanned %0d source bytes and %0d end marks; %0d tokens compared.",
             bytes_in, marks_in, tokens_checked);
    $display("Kinds seen: %0d var, %0d ident, %0d integer, %0d error, %0d end.",
             kind_seen[csc_pkg::KIND_VAR], kind_seen[csc_pkg::KIND_IDENT],
             kind_seen[csc_pkg::KIND_INT], kind_seen[csc_pkg::KIND_ERROR],
             kind_seen[csc_pkg::KIND_END]);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
